@@ src/lfpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and field widths for the lidar frame point decoder.
// No dependencies.
package lfpd_pkg;

  // Fixed frame layout: offsets ahead of the point block and field sizes
  localparam int POS_SPEED_LO    = 2;
  localparam int POS_START_LO    = 4;
  localparam int POS_POINTS      = 6;
  localparam int BYTES_PER_POINT = 3;
  localparam int ANGLE_BYTES     = 2;
  localparam int TS_BYTES        = 2;

  // Widths of the raw fields
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int PNUM_W  = 4;
  localparam int DIV_W   = 17;  // reciprocal divider dividend width
  localparam int ANGLE_W = 18;  // signed angle arithmetic

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;

endpackage : lfpd_pkg

@@ src/lidar_frame_point_decoder_top.sv @@
`timescale 1ns / 1ps
// Lidar frame point decoder: byte capture, point store and angle sequencer.
// Depends on lfpd_pkg.

// Frame bytes are taken one per cycle (in_stall low) until the byte that
// completes the timestamp. The block then stalls its input and emits
// POINTS_PER_FRAME point items in order. All angle arithmetic runs through a
// single shared 17x18 multiplier with reciprocal constants: two passes
// (quotient, then remainder) for the slope arc / (POINTS_PER_FRAME-1), and two
// passes per point for the reduction into 0 .. ANGLE_FULL_SCALE-1. The input
// stays stalled from the last timestamp byte until the final point item is taken.
// CRC and trailing bytes are dropped until the next frame_start.
module lidar_frame_point_decoder_top #(
  parameter int POINTS_PER_FRAME = 12,
  parameter int ANGLE_FULL_SCALE = 36000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lfpd_pkg::byte_t       in_frame_byte,
  input  logic                  in_frame_start,
  // point output
  output logic                  out_valid,
  input  logic                  out_stall,
  output lfpd_pkg::word_t       out_point_distance,
  output lfpd_pkg::byte_t       out_point_intensity,
  output lfpd_pkg::word_t       out_point_angle,
  output logic [3:0]            out_point_number,
  output lfpd_pkg::word_t       out_scan_speed,
  output lfpd_pkg::word_t       out_first_angle,
  output lfpd_pkg::word_t       out_final_angle,
  output lfpd_pkg::word_t       out_frame_timestamp,
  output logic                  out_last_point
);
  import lfpd_pkg::*;

  localparam int POS_END_LO = POS_POINTS + BYTES_PER_POINT * POINTS_PER_FRAME;
  localparam int POS_TS_LO  = POS_END_LO + ANGLE_BYTES;
  localparam int POS_TS_HI  = POS_TS_LO + 1;
  localparam int POS_IDLE   = POS_TS_HI + 1;
  localparam int POS_W      = $clog2(POS_IDLE + 1);
  localparam int PT_W       = $clog2(POINTS_PER_FRAME);
  localparam int RW         = $clog2(POINTS_PER_FRAME);
  localparam int MUL_W      = 2 * DIV_W + 1;

  // floor(x/d) = (x*M) >> K for every x below 2**DIV_W
  localparam int SEG_K = DIV_W + $clog2(POINTS_PER_FRAME - 1);
  localparam int FS_K  = DIV_W + $clog2(ANGLE_FULL_SCALE);
  localparam logic [DIV_W:0] SEG_M = (DIV_W+1)'(((64'd1 << SEG_K)
      + 64'(POINTS_PER_FRAME - 2)) / 64'(POINTS_PER_FRAME - 1));
  localparam logic [DIV_W:0] FS_M  = (DIV_W+1)'(((64'd1 << FS_K)
      + 64'(ANGLE_FULL_SCALE - 1)) / 64'(ANGLE_FULL_SCALE));

  localparam logic [PT_W-1:0]         PT_LAST = PT_W'(POINTS_PER_FRAME - 1);
  localparam logic [WORD_W-1:0]       SEG_DEN = WORD_W'(POINTS_PER_FRAME - 1);
  localparam logic [WORD_W-1:0]       FS_DEN  = WORD_W'(ANGLE_FULL_SCALE);
  localparam logic signed [ANGLE_W-1:0] FS_S   = ANGLE_W'(ANGLE_FULL_SCALE);
  localparam logic signed [ANGLE_W-1:0] HALF_S = ANGLE_W'(ANGLE_FULL_SCALE / 2);

  typedef enum logic [2:0] {
    S_IN, S_SETUP, S_SQ, S_SR, S_ANG, S_MQ, S_MR, S_OUT
  } state_t;

  state_t             state_r;
  logic [POS_W-1:0]   byte_pos_r;
  logic [PT_W-1:0]    wr_pt_r;
  logic [1:0]         wr_sub_r;
  word_t              pt_bytes_r;
  word_t              speed_r, start_r, end_r;
  byte_t              ts_lo_r, ts_hi_r;

  logic [2*BYTE_W+BYTE_W-1:0] pt_store [POINTS_PER_FRAME];
  logic [2*BYTE_W+BYTE_W-1:0] rd_data_r;

  logic [PT_W-1:0]    pt_r;
  logic               seg_neg_r, a_neg_r;
  word_t              qd_r, q_r;
  logic [RW-1:0]      rd_r, r_r;
  logic [DIV_W-1:0]   mag_r, quo_r;
  logic               out_valid_r;
  word_t              out_dist_r, out_angle_r;
  byte_t              out_int_r;

  // byte decode
  logic               in_acc, wr_en;
  logic [POS_W-1:0]   pos, pos_nxt;

  // shared multiplier
  logic [DIV_W-1:0]   mul_a;
  logic [DIV_W:0]     mul_b;
  logic [MUL_W-1:0]   prod;
  logic [DIV_W-1:0]   quo_nxt, rem_full;
  word_t              rem_w;

  // angle helpers
  logic signed [ANGLE_W-1:0] seg_d, seg_adj, ang_a;
  logic [DIV_W-1:0]   seg_mag, ang_mag;
  logic [DIV_W-1:0]   q_sum;
  logic [RW:0]        r_sum;
  logic               r_wrap;
  word_t              angle_nxt;
  logic [PT_W+3:0]    pt_ext;

  assign in_stall = (state_r != S_IN);
  assign in_acc   = in_valid && !in_stall;
  assign pos      = in_frame_start ? '0 : byte_pos_r;
  assign pos_nxt  = (pos >= POS_W'(POS_IDLE)) ? POS_W'(POS_IDLE) : pos + 1'b1;
  assign wr_en    = in_acc && (pos >= POS_W'(POS_POINTS)) && (pos < POS_W'(POS_END_LO))
                    && (wr_sub_r == 2'd2);

  always_comb begin
    unique case (state_r)
      S_SQ: begin
        mul_a = mag_r;
        mul_b = SEG_M;
      end
      S_SR: begin
        mul_a = quo_r;
        mul_b = {2'b00, SEG_DEN};
      end
      S_MQ: begin
        mul_a = mag_r;
        mul_b = FS_M;
      end
      default: begin
        mul_a = quo_r;
        mul_b = {2'b00, FS_DEN};
      end
    endcase
    prod     = MUL_W'(mul_a) * MUL_W'(mul_b);
    quo_nxt  = (state_r == S_SQ) ? DIV_W'(prod >> SEG_K) : DIV_W'(prod >> FS_K);
    // quotient times divisor never exceeds the dividend
    rem_full = mag_r - prod[DIV_W-1:0];
    rem_w    = rem_full[WORD_W-1:0];

    // shorter-arc difference
    seg_d = $signed({2'b00, end_r}) - $signed({2'b00, start_r});
    if (seg_d > HALF_S) begin
      seg_adj = seg_d - FS_S;
    end else if (seg_d < -HALF_S) begin
      seg_adj = seg_d + FS_S;
    end else begin
      seg_adj = seg_d;
    end
    seg_mag = seg_adj[ANGLE_W-1] ? DIV_W'(-seg_adj) : DIV_W'(seg_adj);

    ang_a   = seg_neg_r ? $signed({2'b00, start_r}) - $signed({2'b00, q_r})
                        : $signed({2'b00, start_r}) + $signed({2'b00, q_r});
    ang_mag = ang_a[ANGLE_W-1] ? DIV_W'(-ang_a) : DIV_W'(ang_a);

    // C-style remainder folded back into the positive circle
    angle_nxt = (a_neg_r && (rem_w != '0)) ? FS_DEN - rem_w : rem_w;

    // running quotient/remainder of arc*i/(N-1)
    q_sum  = {1'b0, q_r} + {1'b0, qd_r};
    r_sum  = {1'b0, r_r} + {1'b0, rd_r};
    r_wrap = (r_sum >= (RW+1)'(POINTS_PER_FRAME - 1));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_store[wr_pt_r] <= {in_frame_byte, pt_bytes_r};
    end
    rd_data_r <= pt_store[pt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      byte_pos_r  <= '0;
      wr_pt_r     <= '0;
      wr_sub_r    <= '0;
      speed_r     <= '0;
      start_r     <= '0;
      end_r       <= '0;
      ts_lo_r     <= '0;
      ts_hi_r     <= '0;
      pt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IN: begin
          if (in_acc) begin
            byte_pos_r <= pos_nxt;
            if (pos < POS_W'(POS_POINTS)) begin
              wr_pt_r  <= '0;
              wr_sub_r <= '0;
            end else if (pos < POS_W'(POS_END_LO)) begin
              if (wr_sub_r == 2'd2) begin
                wr_sub_r <= '0;
                wr_pt_r  <= wr_pt_r + 1'b1;
              end else begin
                wr_sub_r <= wr_sub_r + 1'b1;
              end
            end
            if (wr_sub_r == 2'd0) pt_bytes_r[BYTE_W-1:0]      <= in_frame_byte;
            if (wr_sub_r == 2'd1) pt_bytes_r[WORD_W-1:BYTE_W] <= in_frame_byte;

            if (pos == POS_W'(POS_SPEED_LO))     speed_r[BYTE_W-1:0]      <= in_frame_byte;
            if (pos == POS_W'(POS_SPEED_LO + 1)) speed_r[WORD_W-1:BYTE_W] <= in_frame_byte;
            if (pos == POS_W'(POS_START_LO))     start_r[BYTE_W-1:0]      <= in_frame_byte;
            if (pos == POS_W'(POS_START_LO + 1)) start_r[WORD_W-1:BYTE_W] <= in_frame_byte;
            if (pos == POS_W'(POS_END_LO))       end_r[BYTE_W-1:0]        <= in_frame_byte;
            if (pos == POS_W'(POS_END_LO + 1))   end_r[WORD_W-1:BYTE_W]   <= in_frame_byte;
            if (pos == POS_W'(POS_TS_LO))        ts_lo_r                  <= in_frame_byte;
            if (pos == POS_W'(POS_TS_HI)) begin
              ts_hi_r <= in_frame_byte;
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          seg_neg_r <= seg_adj[ANGLE_W-1];
          mag_r     <= seg_mag;
          pt_r      <= '0;
          q_r       <= '0;
          r_r       <= '0;
          state_r   <= S_SQ;
        end
        S_SQ: begin
          quo_r   <= quo_nxt;
          state_r <= S_SR;
        end
        S_SR: begin
          qd_r    <= quo_r[WORD_W-1:0];
          rd_r    <= rem_full[RW-1:0];
          state_r <= S_ANG;
        end
        S_ANG: begin
          a_neg_r <= ang_a[ANGLE_W-1];
          mag_r   <= ang_mag;
          state_r <= S_MQ;
        end
        S_MQ: begin
          quo_r   <= quo_nxt;
          state_r <= S_MR;
        end
        S_MR: begin
          out_angle_r <= angle_nxt;
          out_dist_r  <= rd_data_r[WORD_W-1:0];
          out_int_r   <= rd_data_r[WORD_W+BYTE_W-1:WORD_W];
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (pt_r == PT_LAST) begin
              state_r <= S_IN;
            end else begin
              pt_r    <= pt_r + 1'b1;
              q_r     <= r_wrap ? WORD_W'(q_sum + 1'b1) : q_sum[WORD_W-1:0];
              r_r     <= r_wrap ? RW'(r_sum - (RW+1)'(POINTS_PER_FRAME - 1))
                                : r_sum[RW-1:0];
              state_r <= S_ANG;
            end
          end
        end
      endcase
    end
  end

  assign pt_ext              = {4'b0000, pt_r};
  assign out_valid           = out_valid_r;
  assign out_point_distance  = out_dist_r;
  assign out_point_intensity = out_int_r;
  assign out_point_angle     = out_angle_r;
  assign out_point_number    = pt_ext[PNUM_W-1:0];
  assign out_scan_speed      = speed_r;
  assign out_first_angle     = start_r;
  assign out_final_angle     = end_r;
  assign out_frame_timestamp = {ts_hi_r, ts_lo_r};
  assign out_last_point      = (pt_r == PT_LAST);

  // no byte is taken while a point item is pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while point item pending");

  // reciprocal quotient is exact: remainder stays below the full scale
  a_mod_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MR) |-> (rem_full < DIV_W'(ANGLE_FULL_SCALE)))
    else $error("divider remainder out of range");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_angle < FS_DEN))
    else $error("point angle outside full circle");

  // after the final point the byte input opens again
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_point) |=> !in_stall)
    else $error("input not reopened after last point");

  // running remainder of the interpolation stays below the segment count
  a_seg_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ANG) |-> ({1'b0, r_r} < (RW+1)'(POINTS_PER_FRAME - 1)))
    else $error("interpolation remainder out of range");

endmodule : lidar_frame_point_decoder_top
